FILE: sv/tmrle_pkg.sv
// Package for the tile-map run-length encoder.
// Holds the cell and word types, word constants and the register index codes.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package tmrle_pkg;

	localparam int WordW = 16;
	localparam int IndexW = 11;
	localparam int CountW = 13;
	localparam int MaxWords = 3;

	localparam logic [WordW-1:0] BlankFlag = 16'h2000;
	localparam logic [CountW-1:0] BlankMax = 13'h1fff;
	localparam logic [CountW-1:0] TileRunMax = 13'd7;
	localparam logic [WordW-1:0] Terminator = 16'hffff;
	localparam int RunShift = 13;

	typedef enum logic [0:0] {
		CFG_MAP_WIDTH = 1'b0,
		CFG_TILE_OFFSET = 1'b1
	} cfg_index_t;

	typedef struct packed {
		logic              is_blank;
		logic [IndexW-1:0] tile_index;
		logic              flip_h;
		logic              flip_v;
		logic              last_cell;
	} cell_t;

	typedef struct packed {
		logic [WordW-1:0] map_word;
		logic             last_word;
	} word_t;

	typedef struct packed {
		logic [1:0]             count;
		word_t [MaxWords-1:0]   words;
	} batch_t;

	function automatic logic [WordW-1:0] run_word(
		input logic              blank,
		input logic [IndexW-1:0] index,
		input logic              fh,
		input logic              fv,
		input logic [CountW-1:0] count,
		input logic [IndexW-1:0] offset
	);
		logic [WordW-1:0] w;
		if (blank) begin
			w = BlankFlag | {3'b000, count & BlankMax};
		end else begin
			w = {5'b00000, IndexW'(offset + index)};
			if (count > 13'd1) begin
				w[WordW-1:RunShift] = count[2:0];
			end
			w[11] = fh;
			w[12] = fv;
		end
		return w;
	endfunction

endpackage

FILE: sv/tmrle_core.sv
// Run tracking for the tile-map run-length encoder: run state registers and
// the combinational step that turns one cell into up to three output words.
// Depends on tmrle_pkg.
`timescale 1ns / 1ps

module tmrle_core
	import tmrle_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  cell_t             cur_cell,
	input  logic [WordW-1:0]  map_width,
	input  logic [IndexW-1:0] tile_offset,
	output batch_t            batch
);

	logic              header_sent_q;
	logic              run_open_q;
	logic              run_blank_q;
	logic [IndexW-1:0] run_index_q;
	logic              run_flip_h_q;
	logic              run_flip_v_q;
	logic [CountW-1:0] run_count_q;

	logic              header_sent_d;
	logic              run_open_d;
	logic              run_blank_d;
	logic [IndexW-1:0] run_index_d;
	logic              run_flip_h_d;
	logic              run_flip_v_d;
	logic [CountW-1:0] run_count_d;

	logic              open0;
	logic [CountW-1:0] count0;
	logic              match;
	logic              close;
	logic [1:0]        n;

	always_comb begin
		batch = '0;
		n = 2'd0;
		header_sent_d = header_sent_q;
		run_blank_d = run_blank_q;
		run_index_d = run_index_q;
		run_flip_h_d = run_flip_h_q;
		run_flip_v_d = run_flip_v_q;
		open0 = run_open_q;
		count0 = run_count_q;
		close = 1'b0;

		if (!header_sent_q) begin
			open0 = 1'b0;
			count0 = '0;
			batch.words[n] = '{map_word: map_width, last_word: 1'b0};
			n = n + 2'd1;
			header_sent_d = 1'b1;
		end

		if (cur_cell.is_blank) begin
			match = open0 && run_blank_q;
		end else begin
			match = open0 && !run_blank_q && (run_index_q == cur_cell.tile_index) &&
				(run_flip_h_q == cur_cell.flip_h) && (run_flip_v_q == cur_cell.flip_v);
		end

		run_open_d = open0;
		run_count_d = count0;
		if (match) begin
			run_count_d = count0 + 13'd1;
			close = run_blank_q ? (run_count_d >= BlankMax) : (run_count_d >= TileRunMax);
			if (close) begin
				batch.words[n] = '{map_word: run_word(run_blank_q, run_index_q,
					run_flip_h_q, run_flip_v_q, run_count_d, tile_offset), last_word: 1'b0};
				n = n + 2'd1;
				run_open_d = 1'b0;
				run_count_d = '0;
			end
		end else begin
			if (open0) begin
				batch.words[n] = '{map_word: run_word(run_blank_q, run_index_q,
					run_flip_h_q, run_flip_v_q, count0, tile_offset), last_word: 1'b0};
				n = n + 2'd1;
			end
			run_open_d = 1'b1;
			run_blank_d = cur_cell.is_blank;
			run_index_d = cur_cell.is_blank ? '0 : cur_cell.tile_index;
			run_flip_h_d = cur_cell.is_blank ? 1'b0 : cur_cell.flip_h;
			run_flip_v_d = cur_cell.is_blank ? 1'b0 : cur_cell.flip_v;
			run_count_d = 13'd1;
		end

		if (cur_cell.last_cell) begin
			if (run_open_d) begin
				batch.words[n] = '{map_word: run_word(run_blank_d, run_index_d,
					run_flip_h_d, run_flip_v_d, run_count_d, tile_offset), last_word: 1'b0};
				n = n + 2'd1;
			end
			batch.words[n] = '{map_word: Terminator, last_word: 1'b1};
			n = n + 2'd1;
			run_open_d = 1'b0;
			run_count_d = '0;
			header_sent_d = 1'b0;
			run_blank_d = 1'b0;
			run_index_d = '0;
			run_flip_h_d = 1'b0;
			run_flip_v_d = 1'b0;
		end
		batch.count = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_sent_q <= 1'b0;
			run_open_q <= 1'b0;
			run_blank_q <= 1'b0;
			run_index_q <= '0;
			run_flip_h_q <= 1'b0;
			run_flip_v_q <= 1'b0;
			run_count_q <= '0;
		end else if (step) begin
			header_sent_q <= header_sent_d;
			run_open_q <= run_open_d;
			run_blank_q <= run_blank_d;
			run_index_q <= run_index_d;
			run_flip_h_q <= run_flip_h_d;
			run_flip_v_q <= run_flip_v_d;
			run_count_q <= run_count_d;
		end
	end

endmodule

FILE: sv/tmrle_out_fifo.sv
// Four-entry output queue of the tile-map run-length encoder.
// Takes up to three words at once and hands out one word per cycle while the receiver is ready.
// Depends on tmrle_pkg.
`timescale 1ns / 1ps

module tmrle_out_fifo
	import tmrle_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  batch_t batch,
	output logic   room,
	output logic   valid,
	input  logic   ready,
	output word_t  head
);

	localparam int Depth = 4;

	word_t      entry_q [Depth];
	logic [1:0] rd_ptr_q;
	logic [1:0] wr_ptr_q;
	logic [2:0] count_q;
	logic       pop;
	logic [1:0] n_push;
	logic [2:0] count_after_pop;

	assign valid = (count_q != 3'd0);
	assign pop = valid && ready;
	assign head = entry_q[rd_ptr_q];
	assign count_after_pop = count_q - {2'b00, pop};
	assign room = (count_after_pop <= 3'd1);
	assign n_push = push ? batch.count : 2'd0;

	always_ff @(posedge clk) begin
		for (int e = 0; e < Depth; e++) begin
			logic [1:0] off;
			off = 2'(e) - wr_ptr_q;
			if (off < n_push) begin
				entry_q[e] <= batch.words[off];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q <= '0;
		end else begin
			rd_ptr_q <= rd_ptr_q + {1'b0, pop};
			wr_ptr_q <= wr_ptr_q + n_push;
			count_q <= count_after_pop + {1'b0, n_push};
		end
	end

endmodule

FILE: sv/tilemap_run_length_encoder_unit.sv
// Tile-map run-length encoder, top level.
// Holds the input register, the configuration registers and the two parts.
// Depends on tmrle_pkg, tmrle_core and tmrle_out_fifo.
//
// Cells enter on the s_ stream, one word per cell: s_tuser carries the blank
// mark, s_tlast marks the last cell of a map. Encoded words leave on the m_
// stream; m_tlast is high on the 0xFFFF terminator that closes a map.
// The configuration port writes map_width (index 0) and the tile offset
// (index 1); the user must see that it is written only while the block is
// idle, as the block itself does not enforce this. A cell is captured in an
// input register and, once the queue has room, stepped into a four-entry
// output queue, from which its first word appears on the m_ stream.
// One cell is taken per cycle as long as the queue holds at most one word
// after this cycle's read; even with the receiver ready, cells that give two
// words can fill the queue and hold the input, and a cell that gives three (a
// one-cell map, or a last cell that ends one run and starts another) always
// holds the input after it.
// When the receiver stalls, the queue fills and s_tready falls; no word is
// lost. Reset clears the run state, the queue and both registers.
`timescale 1ns / 1ps

module tilemap_run_length_encoder_unit
	import tmrle_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [15:0]       s_tdata,   // tile_index [10:0], flip_h [11], flip_v [12], zero
	input  logic              s_tuser,   // is_blank
	input  logic              s_tlast,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [WordW-1:0]  m_tdata,   // map_word
	output logic              m_tlast,
	input  logic              cfg_we,
	input  cfg_index_t        cfg_index,
	input  logic [WordW-1:0]  cfg_wdata
);

	logic              valid_s1;
	cell_t             cell_s1;
	logic [WordW-1:0]  map_width_q;
	logic [IndexW-1:0] tile_offset_q;
	logic              room;
	logic              step;
	batch_t            batch;
	word_t             head;

	assign step = valid_s1 && room;
	assign s_tready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cell_s1 <= '{is_blank: s_tuser, tile_index: s_tdata[10:0],
				flip_h: s_tdata[11], flip_v: s_tdata[12], last_cell: s_tlast};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_width_q <= '0;
			tile_offset_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MAP_WIDTH: map_width_q <= cfg_wdata;
				CFG_TILE_OFFSET: tile_offset_q <= cfg_wdata[IndexW-1:0];
				default: ;
			endcase
		end
	end

	tmrle_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.cur_cell    (cell_s1),
		.map_width   (map_width_q),
		.tile_offset (tile_offset_q),
		.batch       (batch)
	);

	tmrle_out_fifo u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (step),
		.batch  (batch),
		.room   (room),
		.valid  (m_tvalid),
		.ready  (m_tready),
		.head   (head)
	);

	assign m_tdata = head.map_word;
	assign m_tlast = head.last_word;

endmodule

FILE: tb/tb_tilemap_run_length_encoder_unit.sv
// Testbench for the tile-map run-length encoder: directed maps and random maps
// under varying stalls, checked word by word against a predictor.
// Depends on tmrle_pkg and tilemap_run_length_encoder_unit.
`timescale 1ns / 1ps

module tb_tilemap_run_length_encoder_unit;
	import tmrle_pkg::*;

	localparam logic [15:0] BLANK_RUN_FLAG = 16'h2000;
	localparam logic [12:0] BLANK_RUN_MAX = 13'h1fff;
	localparam logic [12:0] TILE_RUN_LIMIT = 13'd7;
	localparam logic [15:0] END_WORD = 16'hffff;
	localparam int DRAIN_CYCLES = 12;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [15:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [WordW-1:0] m_tdata;
	logic m_tlast;
	logic cfg_we = 1'b0;
	cfg_index_t cfg_index = CFG_MAP_WIDTH;
	logic [WordW-1:0] cfg_wdata = '0;

	tilemap_run_length_encoder_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	cell_t pending_cells[$];
	word_t expected_words[$];
	cell_t cell_on_bus = '0;
	int send_idle_pct = 35;
	int recv_idle_pct = 88;
	int mismatches = 0;

	// Predictor copy of the registers and the run state.
	logic [15:0] width_reg = '0;
	logic [10:0] base_reg = '0;
	logic header_done = 1'b0;
	logic open_run = 1'b0;
	logic open_blank = 1'b0;
	logic [10:0] open_index = '0;
	logic open_fh = 1'b0;
	logic open_fv = 1'b0;
	logic [12:0] open_count = '0;

	function automatic void expect_word(input logic [15:0] value, input logic is_end);
		word_t w;
		w.map_word = value;
		w.last_word = is_end;
		expected_words = {expected_words, w};
	endfunction

	function automatic logic [15:0] run_code();
		logic [15:0] w;
		if (open_blank) begin
			w = BLANK_RUN_FLAG | {3'b000, open_count};
		end else begin
			w = {open_count > 13'd1 ? open_count[2:0] : 3'b000, open_fv, open_fh,
				11'(base_reg + open_index)};
		end
		return w;
	endfunction

	function automatic void close_run();
		if (open_run) begin
			expect_word(run_code(), 1'b0);
		end
		open_run = 1'b0;
		open_count = '0;
	endfunction

	function automatic void encode_cell(input cell_t c);
		logic same;
		if (!header_done) begin
			open_run = 1'b0;
			open_count = '0;
			expect_word(width_reg, 1'b0);
			header_done = 1'b1;
		end
		if (c.is_blank) begin
			same = open_run && open_blank;
		end else begin
			same = open_run && !open_blank && open_index == c.tile_index &&
				open_fh == c.flip_h && open_fv == c.flip_v;
		end
		if (same) begin
			open_count = open_count + 13'd1;
			if ((open_blank && open_count >= BLANK_RUN_MAX) ||
				(!open_blank && open_count >= TILE_RUN_LIMIT)) begin
				close_run();
			end
		end else begin
			close_run();
			open_run = 1'b1;
			open_blank = c.is_blank;
			open_index = c.is_blank ? 11'd0 : c.tile_index;
			open_fh = c.is_blank ? 1'b0 : c.flip_h;
			open_fv = c.is_blank ? 1'b0 : c.flip_v;
			open_count = 13'd1;
		end
		if (c.last_cell) begin
			close_run();
			expect_word(END_WORD, 1'b1);
			header_done = 1'b0;
			open_blank = 1'b0;
			open_index = '0;
			open_fh = 1'b0;
			open_fv = 1'b0;
		end
	endfunction

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("tilemap_run_length_encoder_unit test failed");
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				encode_cell(cell_on_bus);
			end
			if (!s_tvalid || s_tready) begin
				if (pending_cells.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					cell_t c;
					c = pending_cells.pop_front();
					cell_on_bus <= c;
					s_tvalid <= 1'b1;
					s_tdata <= {3'b000, c.flip_v, c.flip_h, c.tile_index};
					s_tuser <= c.is_blank;
					s_tlast <= c.last_cell;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_words.size() == 0) begin
					$display("%0t: unexpected word: expected none, actual %h last %b",
						$time, m_tdata, m_tlast);
					mismatches++;
				end else begin
					word_t w;
					w = expected_words.pop_front();
					if (m_tdata !== w.map_word) begin
						$display("%0t: map word mismatch: expected %h, actual %h",
							$time, w.map_word, m_tdata);
						mismatches++;
					end
					if (m_tlast !== w.last_word) begin
						$display("%0t: last flag mismatch: expected %b, actual %b",
							$time, w.last_word, m_tlast);
						mismatches++;
					end
				end
			end
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic queue_cell(input logic blank, input logic [10:0] index,
		input logic fh, input logic fv, input logic last);
		cell_t c;
		c.is_blank = blank;
		c.tile_index = index;
		c.flip_h = fh;
		c.flip_v = fv;
		c.last_cell = last;
		pending_cells = {pending_cells, c};
	endtask

	task automatic drain();
		while (pending_cells.size() > 0 || s_tvalid || expected_words.size() > 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [15:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_MAP_WIDTH) begin
			width_reg = value;
		end else begin
			base_reg = value[10:0];
		end
	endtask

	task automatic queue_random_map(input int cells);
		int left;
		int len;
		int k;
		cell_t c;
		cell_t n;
		left = cells;
		while (left > 0) begin
			len = $urandom_range(1, 10);
			if (len > left) begin
				len = left;
			end
			c.is_blank = ($urandom_range(3) == 0);
			c.tile_index = $urandom_range(1) ? 11'($urandom_range(3)) :
				11'($urandom_range(2047));
			c.flip_h = 1'($urandom_range(1));
			c.flip_v = 1'($urandom_range(1));
			for (k = 0; k < len; k++) begin
				n = c;
				if (n.is_blank) begin
					n.tile_index = 11'($urandom_range(2047));
					n.flip_h = 1'($urandom_range(1));
					n.flip_v = 1'($urandom_range(1));
				end else if ($urandom_range(15) == 0) begin
					n.flip_h = ~n.flip_h;
				end
				n.last_cell = (left == 1);
				pending_cells = {pending_cells, n};
				left--;
			end
		end
	endtask

	task automatic run_random_phase(input int items);
		int queued;
		int cells;
		queued = 0;
		while (queued < items) begin
			cells = $urandom_range(1) ? $urandom_range(1, 12) : $urandom_range(13, 30);
			queue_random_map(cells);
			queued += cells;
		end
		drain();
	endtask

	initial begin
		int k;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset register values: one-cell maps, tile and blank.
		queue_cell(1'b0, 11'h7ff, 1'b1, 1'b1, 1'b1);
		queue_cell(1'b1, 11'h7ff, 1'b1, 1'b1, 1'b1);
		drain();

		write_reg(CFG_MAP_WIDTH, 16'hffff);
		write_reg(CFG_TILE_OFFSET, 16'h07ff);
		for (k = 0; k < 8; k++) begin
			queue_cell(1'b0, 11'd0, 1'b0, 1'b0, 1'b0);
		end
		drain();
		queue_cell(1'b1, 11'h555, 1'b1, 1'b0, 1'b0);
		queue_cell(1'b1, 11'h2aa, 1'b0, 1'b1, 1'b0);
		queue_cell(1'b1, 11'h7ff, 1'b1, 1'b1, 1'b0);
		queue_cell(1'b0, 11'd1, 1'b1, 1'b0, 1'b0);
		queue_cell(1'b0, 11'd1, 1'b0, 1'b1, 1'b0);
		queue_cell(1'b0, 11'd1, 1'b0, 1'b1, 1'b0);
		queue_cell(1'b0, 11'h400, 1'b1, 1'b1, 1'b0);
		queue_cell(1'b1, 11'd0, 1'b0, 1'b0, 1'b1);
		drain();

		write_reg(CFG_MAP_WIDTH, 16'h0000);
		write_reg(CFG_TILE_OFFSET, 16'h0000);
		queue_cell(1'b0, 11'h7ff, 1'b0, 1'b0, 1'b0);
		queue_cell(1'b0, 11'h7ff, 1'b0, 1'b0, 1'b1);
		drain();

		write_reg(CFG_MAP_WIDTH, 16'($urandom_range(65535)));
		write_reg(CFG_TILE_OFFSET, 16'($urandom_range(2047)));
		run_random_phase(75);

		send_idle_pct = 88;
		recv_idle_pct = 35;
		write_reg(CFG_MAP_WIDTH, 16'($urandom_range(65535)));
		write_reg(CFG_TILE_OFFSET, 16'($urandom_range(2047)));
		run_random_phase(75);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(CFG_MAP_WIDTH, 16'h8001);
		write_reg(CFG_TILE_OFFSET, 16'h0400);
		run_random_phase(65);

		if (mismatches == 0) begin
			$display("tilemap_run_length_encoder_unit test passed");
		end else begin
			$display("tilemap_run_length_encoder_unit test failed");
		end
		$finish;
	end

endmodule

FILE: sim.f
sv/tmrle_pkg.sv
sv/tmrle_core.sv
sv/tmrle_out_fifo.sv
sv/tilemap_run_length_encoder_unit.sv
tb/tb_tilemap_run_length_encoder_unit.sv
